// ----- rtl/ddo_pkg.sv -----
// Shared types, constants and helper functions for the differential drive odometry block.
// No dependencies; imported by ddo_alu and diff_drive_odometry_core.
package ddo_pkg;

  localparam int unsigned CORDIC_STEPS_DEF = 16;

  localparam logic [31:0] DPP_RESET   = 32'd1672115;
  localparam logic [31:0] APP_RESET   = 32'd479505;
  localparam logic [31:0] KINV_Q30    = 32'd652032874;
  localparam logic [31:0] TWO_PI_MEGA = 32'd6283185;
  localparam logic [31:0] US_PER_S    = 32'd1000000;

  localparam int unsigned OPA_W = 64;
  localparam int unsigned OPB_W = 32;
  localparam int unsigned RES_W = 80;

  localparam logic [1:0] CFG_DPP = 2'd0;
  localparam logic [1:0] CFG_APP = 2'd1;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HEAD,
    S_TRAV,
    S_KHI,
    S_KLO,
    S_CORD,
    S_SMUL,
    S_SDIV,
    S_TMUL,
    S_CHI,
    S_CLO,
    S_TDIV,
    S_PUB
  } state_e;

  // Binary angle arctangent of 2^-idx, full turn 2^32, rounded to nearest.
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      5'd31: v = 32'd0;
    endcase
    return v;
  endfunction

  // Apply sign to a magnitude and saturate to 32 signed bits.
  function automatic logic [31:0] sat32(input logic neg, input logic big,
                                        input logic [63:0] mag);
    logic ovf;
    logic [31:0] v;
    ovf = big | (|mag[63:31]);
    if (neg) begin
      v = ovf ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
    end else begin
      v = ovf ? 32'h7FFF_FFFF : mag[31:0];
    end
    return v;
  endfunction

  // Clamp a wide signed sum to 32 signed bits.
  function automatic logic [31:0] clamp32(input logic signed [60:0] v);
    logic [31:0] r;
    if (v > 61'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -61'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/ddo_alu.sv -----
// Shared bit-serial arithmetic unit: shift-add multiplier and restoring divider.
// Depends on ddo_pkg for the request and status structs.
module ddo_alu (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ddo_pkg::alu_req_t          req_i,
  input  logic [ddo_pkg::OPA_W-1:0]  a_i,
  input  logic [ddo_pkg::OPB_W-1:0]  b_i,
  output ddo_pkg::alu_stat_t         stat_o,
  output logic [ddo_pkg::RES_W-1:0]  res_o
);
  import ddo_pkg::*;

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  alu_op_e     op_q, op_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [79:0] acc_q, acc_d;
  logic [79:0] mc_q, mc_d;
  logic [31:0] mp_q, mp_d;
  logic [31:0] rem_q, rem_d;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        fits;

  assign trial = {rem_q, acc_q[63]};
  assign diff  = trial - {1'b0, mp_q};
  assign fits  = trial >= {1'b0, mp_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    mc_d   = mc_q;
    mp_d   = mp_q;
    rem_d  = rem_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      mp_d   = b_i;
      unique case (req_i.op)
        ALU_MUL: begin
          cnt_d = 6'd31;
          acc_d = '0;
          mc_d  = {32'd0, a_i[47:0]};
        end
        ALU_DIV: begin
          cnt_d = 6'd63;
          acc_d = {16'd0, a_i};
          rem_d = '0;
        end
      endcase
    end else if (busy_q) begin
      unique case (op_q)
        ALU_MUL: begin
          if (mp_q[0]) begin
            acc_d = acc_q + mc_q;
          end
          mc_d = {mc_q[78:0], 1'b0};
          mp_d = {1'b0, mp_q[31:1]};
        end
        ALU_DIV: begin
          rem_d = fits ? diff[31:0] : trial[31:0];
          acc_d = {16'd0, acc_q[62:0], fits};
        end
      endcase
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= ALU_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    mc_q  <= mc_d;
    mp_q  <= mp_d;
    rem_q <= rem_d;
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign res_o  = acc_q;

endmodule

// ----- rtl/diff_drive_odometry_core.sv -----
// Differential drive wheel odometry core: heading, CORDIC position update, speed and turn rate.
// Depends on ddo_pkg and the shared serial arithmetic unit ddo_alu.
//
// Each input transaction carries absolute left/right encoder counts and the elapsed
// interval in microseconds (zero counts as one). The block takes one transaction at
// a time: in_ready_o is high only while the sequencer is idle. All products and
// quotients go through one bit-serial unit (ddo_alu). One transaction runs eight
// multiplies, two divides and CORDIC_STEPS rotation steps, and its result may wait
// for the output register to drain. A finished result sits in the output register
// while the next transaction is taken. Configuration writes (index 0: distance per
// pulse, index 1: angle per pulse) are always accepted and should only be issued
// while the block is idle; other indexes are dropped. Position and rates saturate
// to 32 signed bits; heading wraps.
module diff_drive_odometry_core #(
  parameter int unsigned CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] left_count_i,
  input  logic signed [31:0] right_count_i,
  input  logic [23:0]        interval_us_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic [31:0]        heading_o,
  output logic signed [31:0] speed_o,
  output logic signed [31:0] turn_rate_o
);
  import ddo_pkg::*;

  localparam int unsigned STEP_W = $clog2(CORDIC_STEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

  // Control and configuration
  state_e      state_q, state_d;
  logic        go_q, go_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] dpp_q, dpp_d;
  logic [31:0] app_q, app_d;
  logic [31:0] prev_l_q, prev_l_d;
  logic [31:0] prev_r_q, prev_r_d;
  logic [31:0] acc_x_q, acc_x_d;
  logic [31:0] acc_y_q, acc_y_d;

  // Working payload
  logic [31:0]        hdiff_q, hdiff_d;
  logic signed [32:0] s_q, s_d;
  logic signed [32:0] d_q, d_d;
  logic [23:0]        dt_q, dt_d;
  logic [31:0]        head_q, head_d;
  logic [55:0]        t_q, t_d;
  logic [60:0]        khi_q, khi_d;
  logic signed [59:0] x_q, x_d;
  logic signed [59:0] y_q, y_d;
  logic signed [33:0] z_q, z_d;
  logic [STEP_W-1:0]  i_q, i_d;
  logic [63:0]        dvd_q, dvd_d;
  logic [31:0]        speed_q, speed_d;
  logic [31:0]        turn_q, turn_d;
  logic [65:0]        p_q, p_d;
  logic [55:0]        chi_q, chi_d;

  // Output register
  logic [31:0] o_x_q, o_x_d, o_y_q, o_y_d, o_h_q, o_h_d, o_s_q, o_s_d, o_t_q, o_t_d;

  // Shared unit
  alu_req_t          alu_req;
  alu_stat_t         alu_stat;
  logic [OPA_W-1:0]  alu_a;
  logic [OPB_W-1:0]  alu_b;
  logic [RES_W-1:0]  alu_res;
  logic              fin;

  // Helpers
  logic [31:0]        dl, dr;
  logic [32:0]        sm, dm;
  logic [56:0]        x0;
  logic [59:0]        xs;
  logic               fold;
  logic [31:0]        hf;
  logic signed [59:0] nx, ny, rx, ry;
  logic signed [33:0] nz, az;

  ddo_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .stat_o (alu_stat),
    .res_o  (alu_res)
  );

  assign dl = left_count_i - prev_l_q;
  assign dr = right_count_i - prev_r_q;
  assign sm = s_q[32] ? (~s_q + 33'd1) : s_q;
  assign dm = d_q[32] ? (~d_q + 33'd1) : d_q;

  // Prescaled travel: ((t>>25)*K + ((t mod 2^25)*K >> 25)) >> 5, then fold the left half plane.
  assign x0   = 57'((62'(khi_q) + 62'(alu_res[54:25])) >> 5);
  assign xs   = s_q[32] ? (60'd0 - {3'd0, x0}) : {3'd0, x0};
  assign fold = head_q[31] ^ head_q[30];
  assign hf   = fold ? (head_q - 32'h8000_0000) : head_q;

  // One CORDIC rotation step, floor shifts
  assign az = $signed({2'b00, atan_lut(5'(i_q))});
  always_comb begin
    if (!z_q[33]) begin
      nx = x_q - (y_q >>> i_q);
      ny = y_q + (x_q >>> i_q);
      nz = z_q - az;
    end else begin
      nx = x_q + (y_q >>> i_q);
      ny = y_q - (x_q >>> i_q);
      nz = z_q + az;
    end
  end
  assign rx = (nx + 60'sd128) >>> 8;
  assign ry = (ny + 60'sd128) >>> 8;

  assign fin = go_q & alu_stat.done;

  always_comb begin
    state_d     = state_q;
    go_d        = go_q;
    out_valid_d = out_valid_q;
    dpp_d       = dpp_q;
    app_d       = app_q;
    prev_l_d    = prev_l_q;
    prev_r_d    = prev_r_q;
    acc_x_d     = acc_x_q;
    acc_y_d     = acc_y_q;
    hdiff_d     = hdiff_q;
    s_d         = s_q;
    d_d         = d_q;
    dt_d        = dt_q;
    head_d      = head_q;
    t_d         = t_q;
    khi_d       = khi_q;
    x_d         = x_q;
    y_d         = y_q;
    z_d         = z_q;
    i_d         = i_q;
    dvd_d       = dvd_q;
    speed_d     = speed_q;
    turn_d      = turn_q;
    p_d         = p_q;
    chi_d       = chi_q;
    o_x_d       = o_x_q;
    o_y_d       = o_y_q;
    o_h_d       = o_h_q;
    o_s_d       = o_s_q;
    o_t_d       = o_t_q;
    alu_a       = '0;
    alu_b       = '0;
    alu_req     = '{start: 1'b0, op: ALU_MUL};

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_DPP: dpp_d = cfg_data_i;
        CFG_APP: app_d = cfg_data_i;
        default: ;
      endcase
    end

    // Drop the held result once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    // Launch the shared unit on entry to any arithmetic state
    if (!go_q && state_q != S_IDLE && state_q != S_CORD && state_q != S_PUB) begin
      alu_req.start = 1'b1;
      go_d          = 1'b1;
    end
    if (fin) begin
      go_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          prev_l_d = left_count_i;
          prev_r_d = right_count_i;
          hdiff_d  = right_count_i - left_count_i;
          s_d      = $signed({dl[31], dl}) + $signed({dr[31], dr});
          d_d      = $signed({dr[31], dr}) - $signed({dl[31], dl});
          dt_d     = (interval_us_i == 24'd0) ? 24'd1 : interval_us_i;
          go_d     = 1'b0;
          state_d  = S_HEAD;
        end
      end
      S_HEAD: begin
        alu_a = 64'(hdiff_q);
        alu_b = app_q;
        if (fin) begin
          head_d  = alu_res[31:0];
          state_d = S_TRAV;
        end
      end
      S_TRAV: begin
        alu_a = 64'(sm);
        alu_b = dpp_q;
        if (fin) begin
          t_d     = alu_res[64:9];
          state_d = S_KHI;
        end
      end
      S_KHI: begin
        alu_a = 64'(t_q[55:25]);
        alu_b = KINV_Q30;
        if (fin) begin
          khi_d   = alu_res[60:0];
          state_d = S_KLO;
        end
      end
      S_KLO: begin
        alu_a = 64'(t_q[24:0]);
        alu_b = KINV_Q30;
        if (fin) begin
          x_d     = fold ? (60'sd0 - $signed(xs)) : $signed(xs);
          y_d     = '0;
          z_d     = $signed({{2{hf[31]}}, hf});
          i_d     = '0;
          state_d = S_CORD;
        end
      end
      S_CORD: begin
        x_d = nx;
        y_d = ny;
        z_d = nz;
        i_d = i_q + STEP_W'(1);
        if (i_q == LAST_STEP) begin
          acc_x_d = clamp32($signed({{29{acc_x_q[31]}}, acc_x_q}) + $signed({rx[59], rx}));
          acc_y_d = clamp32($signed({{29{acc_y_q[31]}}, acc_y_q}) + $signed({ry[59], ry}));
          go_d    = 1'b0;
          state_d = S_SMUL;
        end
      end
      S_SMUL: begin
        alu_a = {16'd0, t_q[47:0]};
        alu_b = US_PER_S;
        if (fin) begin
          dvd_d   = alu_res[63:0];
          state_d = S_SDIV;
        end
      end
      S_SDIV: begin
        alu_req.op = ALU_DIV;
        alu_a      = dvd_q;
        alu_b      = {dt_q, 8'd0};
        if (fin) begin
          speed_d = sat32(s_q[32], |t_q[55:44], alu_res[63:0]);
          state_d = S_TMUL;
        end
      end
      S_TMUL: begin
        alu_a = 64'(dm);
        alu_b = app_q;
        if (fin) begin
          p_d     = alu_res[65:0];
          state_d = S_CHI;
        end
      end
      S_CHI: begin
        alu_a = {16'd0, p_q[63:16]};
        alu_b = TWO_PI_MEGA;
        if (fin) begin
          chi_d   = alu_res[55:0];
          state_d = S_CLO;
        end
      end
      S_CLO: begin
        alu_a = 64'(p_q[15:0]);
        alu_b = TWO_PI_MEGA;
        if (fin) begin
          dvd_d   = 64'(chi_q) + 64'(alu_res[38:16]);
          state_d = S_TDIV;
        end
      end
      S_TDIV: begin
        alu_req.op = ALU_DIV;
        alu_a      = dvd_q;
        alu_b      = 32'(dt_q);
        if (fin) begin
          turn_d  = sat32(d_q[32], p_q > (66'd1 << 49), alu_res[63:0]);
          state_d = S_PUB;
        end
      end
      S_PUB: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          o_x_d       = acc_x_q;
          o_y_d       = acc_y_q;
          o_h_d       = head_q;
          o_s_d       = speed_q;
          o_t_d       = turn_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      go_q        <= 1'b0;
      out_valid_q <= 1'b0;
      dpp_q       <= DPP_RESET;
      app_q       <= APP_RESET;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      acc_x_q     <= '0;
      acc_y_q     <= '0;
    end else begin
      state_q     <= state_d;
      go_q        <= go_d;
      out_valid_q <= out_valid_d;
      dpp_q       <= dpp_d;
      app_q       <= app_d;
      prev_l_q    <= prev_l_d;
      prev_r_q    <= prev_r_d;
      acc_x_q     <= acc_x_d;
      acc_y_q     <= acc_y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdiff_q <= hdiff_d;
    s_q     <= s_d;
    d_q     <= d_d;
    dt_q    <= dt_d;
    head_q  <= head_d;
    t_q     <= t_d;
    khi_q   <= khi_d;
    x_q     <= x_d;
    y_q     <= y_d;
    z_q     <= z_d;
    i_q     <= i_d;
    dvd_q   <= dvd_d;
    speed_q <= speed_d;
    turn_q  <= turn_d;
    p_q     <= p_d;
    chi_q   <= chi_d;
    o_x_q   <= o_x_d;
    o_y_q   <= o_y_d;
    o_h_q   <= o_h_d;
    o_s_q   <= o_s_d;
    o_t_q   <= o_t_d;
  end

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign pos_x_o     = o_x_q;
  assign pos_y_o     = o_y_q;
  assign heading_o   = o_h_q;
  assign speed_o     = o_s_q;
  assign turn_rate_o = o_t_q;

  // The shared unit must be quiet whenever a new transaction can be taken
  a_idle_alu_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !alu_stat.busy)
    else $error("shared unit busy while idle");

  // A completion only arrives for an operation this sequencer launched
  a_done_launched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_stat.done |-> go_q)
    else $error("unexpected completion from shared unit");

  // An accepted transaction starts with the heading multiply
  a_accept_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_HEAD && !go_q))
    else $error("accept did not start heading multiply");

  // The rotation loop never runs with the unit launched
  a_cord_no_alu: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CORD) |-> !alu_stat.busy)
    else $error("shared unit busy during rotation");

endmodule
